[sv/hsv2rgb_pkg.sv]
// Shared types for the HSV to RGB converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  typedef enum logic [2:0] {
    SECT_RED     = 3'd0,
    SECT_YELLOW  = 3'd1,
    SECT_GREEN   = 3'd2,
    SECT_CYAN    = 3'd3,
    SECT_BLUE    = 3'd4,
    SECT_MAGENTA = 3'd5
  } sector_t;

endpackage

[sv/hsv_to_rgb_converter.sv]
// HSV to RGB converter: four-stage pipeline, one pixel per clock while out_ready does not stall it.
//
//   channel  | ports                                          | direction
//   ---------+------------------------------------------------+----------
//   input    | in_valid, in_ready, in_hue, in_saturation,     | in
//            | in_brightness                                  |
//   result   | out_valid, out_ready, out_red, out_green,      | out
//            | out_blue                                       |
//
// Items pass v1_r, v2_r, v3_r, out_valid_r; one enters per cycle while in_ready is high.
// The depth is set by the two multipliers (brightness x saturation, then x hue fraction),
// the subtractions that form p, q and t, and the divide by full scale ahead of the
// sector select, one per stage.
// Reset clears the stage valid bits only; payload registers hold whatever they had.
// A stage takes a new item when it is empty or its successor takes its item,
// so bubbles close up and a stall at out_ready holds every item in place.
`timescale 1ns / 1ps

module hsv_to_rgb_converter #(
  parameter int HUE_BITS   = 16,
  parameter int COLOR_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [HUE_BITS-1:0]   in_hue,
  input  logic [COLOR_BITS-1:0] in_saturation,
  input  logic [COLOR_BITS-1:0] in_brightness,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COLOR_BITS-1:0] out_red,
  output logic [COLOR_BITS-1:0] out_green,
  output logic [COLOR_BITS-1:0] out_blue
);

  import hsv2rgb_pkg::*;

  localparam int HB = HUE_BITS;
  localparam int CB = COLOR_BITS;
  localparam int PB = 2 * CB;
  localparam int MB = PB + HB;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  // floor(x / CMAX) for x <= CMAX*CMAX: x = a*2^CB + b = a*CMAX + (a + b)
  function automatic logic [CB-1:0] div_cmax(input logic [PB-1:0] x);
    logic [CB:0]   rem;
    logic [CB-1:0] quo;
    rem = {1'b0, x[PB-1:CB]} + {1'b0, x[CB-1:0]};
    quo = x[PB-1:CB];
    if (rem >= {1'b0, CMAX}) begin
      quo = quo + {{(CB-1){1'b0}}, 1'b1};
    end
    return quo;
  endfunction

  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, out_valid_r;

  // stage 1
  logic [HB+2:0] h6_nxt;
  logic [PB-1:0] vs_nxt;
  sector_t       sect1_r;
  logic [HB-1:0] frac1_r;
  logic [CB-1:0] bri1_r;
  logic [PB-1:0] vs1_r;

  // stage 2
  logic [MB-1:0] prod_nxt;
  logic [PB-1:0] vcm_nxt;
  sector_t       sect2_r;
  logic [CB-1:0] bri2_r;
  logic [PB-1:0] vs2_r;
  logic [PB-1:0] vcm2_r;
  logic [MB-1:0] prod2_r;

  // stage 3
  logic [PB-1:0] hi_nxt;
  logic          lo_nz_nxt;
  logic [PB-1:0] xp_nxt, xq_nxt, xt_nxt;
  sector_t       sect3_r;
  logic [CB-1:0] bri3_r;
  logic [PB-1:0] xp3_r, xq3_r, xt3_r;

  // stage 4
  logic [CB-1:0] p_nxt, q_nxt, t_nxt;
  logic [CB-1:0] red_nxt, green_nxt, blue_nxt;
  logic [CB-1:0] red_r, green_r, blue_r;

  assign en4      = !out_valid_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        out_valid_r <= v3_r;
      end
    end
  end

  assign h6_nxt = ({3'b000, in_hue} << 2) + ({3'b000, in_hue} << 1);
  assign vs_nxt = {{CB{1'b0}}, in_brightness} * {{CB{1'b0}}, in_saturation};

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      sect1_r <= sector_t'(h6_nxt[HB+2:HB]);
      frac1_r <= h6_nxt[HB-1:0];
      bri1_r  <= in_brightness;
      vs1_r   <= vs_nxt;
    end
  end

  assign prod_nxt = {{HB{1'b0}}, vs1_r} * {{PB{1'b0}}, frac1_r};
  assign vcm_nxt  = {bri1_r, {CB{1'b0}}} - {{CB{1'b0}}, bri1_r};

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      sect2_r <= sect1_r;
      bri2_r  <= bri1_r;
      vs2_r   <= vs1_r;
      vcm2_r  <= vcm_nxt;
      prod2_r <= prod_nxt;
    end
  end

  assign hi_nxt    = prod2_r[MB-1:HB];
  assign lo_nz_nxt = |prod2_r[HB-1:0];
  assign xp_nxt    = vcm2_r - vs2_r;
  assign xq_nxt    = vcm2_r - hi_nxt - {{(PB-1){1'b0}}, lo_nz_nxt};
  assign xt_nxt    = vcm2_r - vs2_r + hi_nxt;

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      sect3_r <= sect2_r;
      bri3_r  <= bri2_r;
      xp3_r   <= xp_nxt;
      xq3_r   <= xq_nxt;
      xt3_r   <= xt_nxt;
    end
  end

  assign p_nxt = div_cmax(xp3_r);
  assign q_nxt = div_cmax(xq3_r);
  assign t_nxt = div_cmax(xt3_r);

  always_comb begin
    case (sect3_r)
      SECT_RED: begin
        red_nxt   = bri3_r;
        green_nxt = t_nxt;
        blue_nxt  = p_nxt;
      end
      SECT_YELLOW: begin
        red_nxt   = q_nxt;
        green_nxt = bri3_r;
        blue_nxt  = p_nxt;
      end
      SECT_GREEN: begin
        red_nxt   = p_nxt;
        green_nxt = bri3_r;
        blue_nxt  = t_nxt;
      end
      SECT_CYAN: begin
        red_nxt   = p_nxt;
        green_nxt = q_nxt;
        blue_nxt  = bri3_r;
      end
      SECT_BLUE: begin
        red_nxt   = t_nxt;
        green_nxt = p_nxt;
        blue_nxt  = bri3_r;
      end
      default: begin
        red_nxt   = bri3_r;
        green_nxt = p_nxt;
        blue_nxt  = q_nxt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule
